/* rtl/grid_word_search_assert.svh */
// Assertion macros used by the RTL file gws_back.sv.
`ifndef GRID_WORD_SEARCH_ASSERT_SVH
`define GRID_WORD_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
`define GWS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("grid_word_search assertion failed");
`define GWS_ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("grid_word_search forbidden condition seen");
`else
`define GWS_ASSERT(label, prop)
`define GWS_ASSERT_NEVER(label, cond)
`endif
`endif

/* rtl/gws_pkg.sv */
package gws_pkg;

   localparam int GRID_DIM = 16;
   localparam int MAX_WORD = 16;

   localparam int IDX_W = $clog2(GRID_DIM);
   localparam int DIM_W = $clog2(GRID_DIM + 1);
   localparam int LEN_W = $clog2(MAX_WORD + 1);
   localparam int WIDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int CHAR_W = 8;
   localparam int ROW_BITS = GRID_DIM * CHAR_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int SIZE_W = 5;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_GRID_SIZE = 1'b0;

   typedef enum logic [1:0] {
      OP_GRID_WRITE,
      OP_WORD_CHAR,
      OP_WORD_END
   } op_type;

   typedef struct packed {
      logic       mode;
      logic [3:0] cell_row;
      logic [3:0] cell_col;
      logic [7:0] char_value;
      logic       word_end;
   } req_type;

   typedef struct packed {
      logic       found_horizontal;
      logic [3:0] horiz_row;
      logic [3:0] horiz_col;
      logic       found_vertical;
      logic [3:0] vert_row;
      logic [3:0] vert_col;
      logic       word_overflow;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic [CHAR_W-1:0]  ch;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

endpackage

/* rtl/gws_front.sv */
module gws_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gws_pkg::req_type      req_data,
   output gws_pkg::cmd_chan_type cmd_chan,
   input  logic                  cmd_pop
);

   gws_pkg::cmd_type                  queue_ff [gws_pkg::QUEUE_DEPTH];
   logic [gws_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [gws_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [gws_pkg::QCNT_W-1:0]        count_ff, count_in;
   gws_pkg::cmd_type                  cmd_in;
   logic                              keep;
   logic                              push;

   always_comb begin
      cmd_in.row = gws_pkg::IDX_W'(req_data.cell_row);
      cmd_in.col = gws_pkg::IDX_W'(req_data.cell_col);
      cmd_in.ch  = req_data.char_value;
      keep       = 1'b1;
      if (!req_data.mode) begin
         cmd_in.op = gws_pkg::OP_GRID_WRITE;
         keep = (int'(req_data.cell_row) < gws_pkg::GRID_DIM) &&
                (int'(req_data.cell_col) < gws_pkg::GRID_DIM);
      end else if (req_data.word_end) begin
         cmd_in.op = gws_pkg::OP_WORD_END;
      end else begin
         cmd_in.op = gws_pkg::OP_WORD_CHAR;
      end
   end

   assign req_stall = (count_ff == gws_pkg::QCNT_W'(gws_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall && keep;

   assign cmd_chan.valid = (count_ff != '0);
   assign cmd_chan.cmd   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + gws_pkg::QPTR_W'(1);
      end
      if (cmd_pop) begin
         rd_ptr_in = rd_ptr_ff + gws_pkg::QPTR_W'(1);
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + gws_pkg::QCNT_W'(1);
      end else if (!push && cmd_pop) begin
         count_in = count_ff - gws_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

/* rtl/gws_back.sv */
`include "grid_word_search_assert.svh"

module gws_back (
   input  logic                          clock,
   input  logic                          reset,
   input  gws_pkg::cmd_chan_type         cmd_chan,
   output logic                          cmd_pop,
   input  logic [gws_pkg::SIZE_W-1:0]    grid_size,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gws_pkg::rsp_type              rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                                     state_ff, state_in;
   logic                                          rsp_valid_ff, rsp_valid_in;
   gws_pkg::rsp_type                              rsp_data_ff, rsp_data_in;
   logic [gws_pkg::LEN_W-1:0]                     len_ff, len_in;
   logic                                          ovf_ff, ovf_in;
   logic                                          rdv_ff, rdv_in;

   logic [gws_pkg::ROW_BITS-1:0]                  grid_mem [gws_pkg::GRID_DIM];
   logic [gws_pkg::CHAR_W-1:0]                    word_ff [gws_pkg::MAX_WORD];
   logic [gws_pkg::ROW_BITS-1:0]                  rd_data_ff;

   logic [gws_pkg::DIM_W-1:0]                     rd_row_ff, rd_row_in;
   logic [gws_pkg::IDX_W-1:0]                     pr_ff;
   logic [gws_pkg::GRID_DIM-1:0][gws_pkg::MAX_WORD-1:0] vp_ff, vp_in, vp_next;
   logic                                          h_found_ff, h_found_in;
   logic [gws_pkg::IDX_W-1:0]                     h_row_ff, h_row_in;
   logic [gws_pkg::IDX_W-1:0]                     h_col_ff, h_col_in;
   logic                                          v_found_ff, v_found_in;
   logic [gws_pkg::IDX_W-1:0]                     v_row_ff, v_row_in;
   logic [gws_pkg::IDX_W-1:0]                     v_col_ff, v_col_in;

   logic [gws_pkg::DIM_W-1:0]                     dim;
   logic                                          mem_we;
   logic                                          word_we;
   logic                                          rd_en;
   logic [gws_pkg::CHAR_W-1:0]                    row_char [gws_pkg::GRID_DIM];
   logic [gws_pkg::GRID_DIM-1:0][gws_pkg::MAX_WORD-1:0] eq;
   logic [gws_pkg::GRID_DIM-1:0]                  h_ok;
   logic [gws_pkg::GRID_DIM-1:0]                  v_hit;
   logic [gws_pkg::IDX_W-1:0]                     h_first;
   logic [gws_pkg::IDX_W-1:0]                     v_first;
   logic [gws_pkg::WIDX_W-1:0]                    last_k;

   assign dim = (grid_size > gws_pkg::SIZE_W'(gws_pkg::GRID_DIM)) ?
                gws_pkg::DIM_W'(gws_pkg::GRID_DIM) : gws_pkg::DIM_W'(grid_size);

   assign last_k = gws_pkg::WIDX_W'(len_ff - gws_pkg::LEN_W'(1));

   // One grid row is compared against the word at every start column at once.
   always_comb begin
      for (int c = 0; c < gws_pkg::GRID_DIM; c++) begin
         row_char[c] = rd_data_ff[c*gws_pkg::CHAR_W +: gws_pkg::CHAR_W];
      end
      for (int c = 0; c < gws_pkg::GRID_DIM; c++) begin
         for (int k = 0; k < gws_pkg::MAX_WORD; k++) begin
            eq[c][k] = (row_char[c] == word_ff[k]);
         end
      end
      for (int c = 0; c < gws_pkg::GRID_DIM; c++) begin
         h_ok[c] = (c + int'(len_ff) <= int'(dim));
         for (int k = 0; k < gws_pkg::MAX_WORD; k++) begin
            if ((k < int'(len_ff)) && (c + k < gws_pkg::GRID_DIM)) begin
               h_ok[c] = h_ok[c] &&
                  (row_char[(c + k) % gws_pkg::GRID_DIM] == word_ff[k]);
            end
         end
      end
      for (int c = 0; c < gws_pkg::GRID_DIM; c++) begin
         vp_next[c][0] = eq[c][0];
         for (int k = 1; k < gws_pkg::MAX_WORD; k++) begin
            vp_next[c][k] = vp_ff[c][k-1] && eq[c][k];
         end
         v_hit[c] = vp_next[c][last_k] && (c < int'(dim));
      end
      h_first = '0;
      v_first = '0;
      for (int c = gws_pkg::GRID_DIM - 1; c >= 0; c--) begin
         if (h_ok[c]) begin
            h_first = gws_pkg::IDX_W'(c);
         end
         if (v_hit[c]) begin
            v_first = gws_pkg::IDX_W'(c);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      rd_row_in    = rd_row_ff;
      vp_in        = vp_ff;
      h_found_in   = h_found_ff;
      h_row_in     = h_row_ff;
      h_col_in     = h_col_ff;
      v_found_in   = v_found_ff;
      v_row_in     = v_row_ff;
      v_col_in     = v_col_ff;
      mem_we       = 1'b0;
      word_we      = 1'b0;
      rd_en        = 1'b0;
      cmd_pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_chan.valid) begin
               cmd_pop = 1'b1;
               unique case (cmd_chan.cmd.op) inside
                  gws_pkg::OP_GRID_WRITE: begin
                     mem_we = 1'b1;
                  end
                  gws_pkg::OP_WORD_CHAR, gws_pkg::OP_WORD_END: begin
                     if (len_ff < gws_pkg::LEN_W'(gws_pkg::MAX_WORD)) begin
                        word_we = 1'b1;
                        len_in  = len_ff + gws_pkg::LEN_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               if (cmd_chan.cmd.op == gws_pkg::OP_WORD_END) begin
                  state_in   = ST_SCAN;
                  rd_row_in  = '0;
                  vp_in      = '0;
                  h_found_in = 1'b0;
                  h_row_in   = '0;
                  h_col_in   = '0;
                  v_found_in = 1'b0;
                  v_row_in   = '0;
                  v_col_in   = '0;
               end
            end
         end
         ST_SCAN: begin
            if (rd_row_ff < dim) begin
               rd_en     = 1'b1;
               rd_row_in = rd_row_ff + gws_pkg::DIM_W'(1);
            end
            if (rdv_ff) begin
               vp_in = vp_next;
               if (!h_found_ff && (|h_ok)) begin
                  h_found_in = 1'b1;
                  h_row_in   = pr_ff;
                  h_col_in   = h_first;
               end
               if (!v_found_ff && (|v_hit)) begin
                  v_found_in = 1'b1;
                  v_row_in   = gws_pkg::IDX_W'(int'(pr_ff) - int'(len_ff) + 1);
                  v_col_in   = v_first;
               end
            end else if (rd_row_ff == dim) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.found_horizontal = h_found_ff;
               rsp_data_in.horiz_row        = 4'(h_row_ff);
               rsp_data_in.horiz_col        = 4'(h_col_ff);
               rsp_data_in.found_vertical   = v_found_ff;
               rsp_data_in.vert_row         = 4'(v_row_ff);
               rsp_data_in.vert_col         = 4'(v_col_ff);
               rsp_data_in.word_overflow    = ovf_ff;
               len_in                       = '0;
               ovf_in                       = 1'b0;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rdv_in    = rd_en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rdv_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         rdv_ff       <= rdv_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      rd_row_ff  <= rd_row_in;
      vp_ff      <= vp_in;
      h_found_ff <= h_found_in;
      h_row_ff   <= h_row_in;
      h_col_ff   <= h_col_in;
      v_found_ff <= v_found_in;
      v_row_ff   <= v_row_in;
      v_col_ff   <= v_col_in;
      if (rd_en) begin
         pr_ff <= gws_pkg::IDX_W'(rd_row_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[cmd_chan.cmd.row][{cmd_chan.cmd.col, 3'b000} +: gws_pkg::CHAR_W] <=
            cmd_chan.cmd.ch;
      end
      if (rd_en) begin
         rd_data_ff <= grid_mem[gws_pkg::IDX_W'(rd_row_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (word_we) begin
         word_ff[gws_pkg::WIDX_W'(len_ff)] <= cmd_chan.cmd.ch;
      end
   end

   `GWS_ASSERT(a_len_bound, len_ff <= gws_pkg::LEN_W'(gws_pkg::MAX_WORD))
   `GWS_ASSERT(a_rd_row_bound, (state_ff == ST_SCAN) |-> (rd_row_ff <= dim))
   `GWS_ASSERT(a_result_held, (state_ff == ST_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_DONE))
   `GWS_ASSERT(a_hfound_sticky, (state_ff == ST_SCAN && h_found_ff) |=> h_found_ff)
   `GWS_ASSERT_NEVER(a_read_outside_scan, rdv_ff && state_ff != ST_SCAN)

endmodule

/* rtl/grid_word_search.sv */
// Word search over a square character grid, left to right and top to bottom.
// Items enter on the req_ channel (valid/stall). A mode 0 item writes one grid
// cell; a mode 1 item appends one word character, and word_end on it starts a
// search. Each search returns one transfer on the rsp_ channel with the first
// horizontal and first vertical match in row-major order of start cells.
// The grid_size register (APB, address 0) picks the square part of the grid
// in use and may only be written while no item is in flight.
// Items pass through a four-entry queue to the execution unit. While idle, the
// unit takes grid writes and plain word characters back to back. A search
// reads one grid row per cycle from the row memory, with grid_size taken as at
// most 16, and its result is registered after all rows are read. While a
// search runs, further items fill the queue and then req_stall rises.
// A finished result waits in the output register while rsp_stall is high;
// writes and characters keep flowing until the next search must deliver.
// Reset empties the queue, clears the word and its overflow flag, drops any
// pending result and sets grid_size to 16; grid and word contents stay. The
// user must have cells written before they are read; this is not enforced.
module grid_word_search (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  gws_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output gws_pkg::rsp_type                rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [gws_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [gws_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [gws_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   logic [gws_pkg::SIZE_W-1:0]  grid_size_ff, grid_size_in;
   gws_pkg::cmd_chan_type       cmd_chan;
   logic                        cmd_pop;
   logic                        sel_size;

   assign pready   = 1'b1;
   assign sel_size = (paddr[gws_pkg::CSR_ADDR_W-1:2] == gws_pkg::CSR_GRID_SIZE);

   always_comb begin
      grid_size_in = grid_size_ff;
      if (psel && penable && pwrite && sel_size) begin
         grid_size_in = pwdata[gws_pkg::SIZE_W-1:0];
      end
   end

   assign prdata = sel_size ? gws_pkg::CSR_DATA_W'(grid_size_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= gws_pkg::SIZE_RESET;
      end else begin
         grid_size_ff <= grid_size_in;
      end
   end

   gws_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_chan  (cmd_chan),
      .cmd_pop   (cmd_pop)
   );

   gws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_chan  (cmd_chan),
      .cmd_pop   (cmd_pop),
      .grid_size (grid_size_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
